FILE: rtl/rect_poly_hash_2d_assert.svh
// Assertion macros shared by the rect_poly_hash_2d RTL.
`ifndef RECT_POLY_HASH_2D_ASSERT_SVH
`define RECT_POLY_HASH_2D_ASSERT_SVH
`ifndef SYNTHESIS
`define RPH_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rect_poly_hash_2d assertion failed");
`define RPH_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rect_poly_hash_2d assertion failed");
`else
`define RPH_ASSERT(label, clk, rst, prop)
`define RPH_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: rtl/rph2d_pkg.sv
// Types and constants of the two-dimensional rolling hash block.
`timescale 1ns / 1ps
`default_nettype none
package rph2d_pkg;
  localparam int WORD_W = 31;
  localparam int CNT_W = 5;
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = 3'd4;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_BASE    = 2'd1,
    REG_MINCHAR = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD_B,
    ST_BUILD_COL,
    ST_BUILD_ROW,
    ST_DECODE,
    ST_FETCH,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_V,
    OP_SET,
    OP_ADD,
    OP_SUB,
    OP_TMP
  } acc_op_t;
endpackage
`default_nettype wire

FILE: rtl/rect_poly_hash_2d.sv
// Two-dimensional polynomial rolling hash over a character grid. Cells are
// loaded with tuser low and store their 2D prefix hash; a query with tuser
// high returns one result item with the hash of a rectangle, or bad_query
// set and a zero hash. All modular products run on one bit-serial
// multiplier; each product has a start cycle, the bit cycles and a done
// cycle. An item makes five products, each after a memory fetch. A query
// also passes the output register, where it waits while the previous
// result item is not yet taken. A load outside the grid or a bad query
// skips the products. The first item after reset, or after modulus or
// base is written, first builds the power tables: 2 * GRID_SIZE + 1
// products. The block accepts one item at a time.
`timescale 1ns / 1ps
`default_nettype none
`include "rect_poly_hash_2d_assert.svh"
module rect_poly_hash_2d #(
  parameter int GRID_SIZE = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // ch[7:0], row_a[17:8], col_a[27:18], row_b[37:28], col_b[47:38]
  input  wire logic [47:0] s_tdata,
  // kind
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // rect_hash[30:0], zero fill
  output logic [31:0]      m_tdata,
  // bad_query
  output logic             m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rph2d_pkg::*;

  localparam int PW = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int TW = $clog2(GRID_SIZE + 1);

  state_t state, state_next;

  word_t       modulus;
  word_t       base_value;
  logic [7:0]  min_char;
  logic        powers_ready;

  logic        kind;
  logic [7:0]  ch;
  logic [9:0]  row_a, col_a, row_b, col_b;

  logic [STEP_W-1:0] step;
  logic [TW-1:0]     k;
  word_t       b_reg, rr_reg, pw, acc, tmp, acc_next;
  logic        bad_flag;

  word_t       prefix_store [GRID_SIZE*GRID_SIZE];
  word_t       col_pow [GRID_SIZE+1];
  word_t       row_pow [GRID_SIZE+1];
  word_t       pref_rd, col_rd, row_rd;

  word_t       m_eff, one;
  logic        mul_start, mul_busy, mul_done;
  word_t       mul_x, mul_y, mul_res;
  acc_op_t     op;
  logic        cfg_wr, in_acc;
  logic        load_out, query_bad;
  logic [8:0]  d_val, diff_abs;
  logic        diff_neg;
  logic [9:0]  rd_row, rd_col;
  logic        rd_ok;
  logic [PW-1:0] rd_addr, wr_addr;
  logic [TW-1:0] w_idx, h_idx;
  logic        pref_we, col_we, row_we;
  logic [TW-1:0] tab_wa;
  word_t       tab_wd;
  logic [WORD_W:0] add_s;
  logic        mul_phase;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign in_acc = s_tvalid & s_tready;
  assign m_eff  = (modulus == '0) ? word_t'(1) : modulus;
  assign one    = (m_eff == word_t'(1)) ? '0 : word_t'(1);

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_MODULUS: prdata = {1'b0, modulus};
      REG_BASE:    prdata = {1'b0, base_value};
      REG_MINCHAR: prdata = {24'd0, min_char};
      default:     prdata = '0;
    endcase
  end

  assign load_out  = (32'(row_a) >= GRID_SIZE) || (32'(col_a) >= GRID_SIZE);
  assign query_bad = (row_a > row_b) || (col_a > col_b) ||
                     (32'(row_b) >= GRID_SIZE) || (32'(col_b) >= GRID_SIZE);
  assign d_val     = {1'b0, ch} + 9'd1;
  assign diff_neg  = d_val < {1'b0, min_char};
  assign diff_abs  = diff_neg ? {1'b0, min_char} - d_val : d_val - {1'b0, min_char};
  assign w_idx     = TW'(32'(col_b) - 32'(col_a) + 1);
  assign h_idx     = TW'(32'(row_b) - 32'(row_a) + 1);

  // Neighbor cell read for the current step; a missing neighbor counts as zero.
  always_comb begin
    rd_row = row_b;
    rd_col = col_b;
    rd_ok  = 1'b1;
    op     = OP_SET;
    mul_y  = one;
    if (!kind) begin
      case (step)
        3'd0: begin op = OP_V;   mul_y = one; end
        3'd1: begin
          op = OP_ADD; mul_y = rr_reg;
          rd_row = row_a - 10'd1; rd_col = col_a; rd_ok = row_a != '0;
        end
        3'd2: begin
          op = OP_ADD; mul_y = b_reg;
          rd_row = row_a; rd_col = col_a - 10'd1; rd_ok = col_a != '0;
        end
        3'd3: begin
          op = OP_TMP; mul_y = rr_reg;
          rd_row = row_a - 10'd1; rd_col = col_a - 10'd1;
          rd_ok = (row_a != '0) && (col_a != '0);
        end
        default: begin op = OP_SUB; mul_y = b_reg; end
      endcase
    end else begin
      case (step)
        3'd0: begin op = OP_SET; mul_y = one; end
        3'd1: begin
          op = OP_SUB; mul_y = col_rd;
          rd_col = col_a - 10'd1; rd_ok = col_a != '0;
        end
        3'd2: begin
          op = OP_SUB; mul_y = row_rd;
          rd_row = row_a - 10'd1; rd_ok = row_a != '0;
        end
        3'd3: begin
          op = OP_TMP; mul_y = row_rd;
          rd_row = row_a - 10'd1; rd_col = col_a - 10'd1;
          rd_ok = (row_a != '0) && (col_a != '0);
        end
        default: begin op = OP_ADD; mul_y = col_rd; end
      endcase
    end
    if (state == ST_BUILD_B) begin
      mul_y = one;
    end else if (state == ST_BUILD_COL) begin
      mul_y = b_reg;
    end else if (state == ST_BUILD_ROW) begin
      mul_y = rr_reg;
    end
  end

  assign rd_addr = PW'(32'(rd_row) * GRID_SIZE + 32'(rd_col));
  assign wr_addr = PW'(32'(row_a) * GRID_SIZE + 32'(col_a));

  always_comb begin
    add_s    = {1'b0, acc} + {1'b0, mul_res};
    acc_next = acc;
    case (op)
      OP_V: begin
        if (diff_neg) acc_next = (mul_res == '0) ? '0 : m_eff - mul_res;
        else          acc_next = mul_res;
      end
      OP_SET: acc_next = mul_res;
      OP_ADD: acc_next = (add_s >= {1'b0, m_eff}) ?
                         WORD_W'(add_s - {1'b0, m_eff}) : add_s[WORD_W-1:0];
      OP_SUB: acc_next = (acc >= mul_res) ? acc - mul_res :
                         WORD_W'({1'b0, acc} + {1'b0, m_eff} - {1'b0, mul_res});
      default: acc_next = acc;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_acc) state_next = powers_ready ? ST_DECODE : ST_BUILD_B;
      ST_BUILD_B:   if (mul_done) state_next = ST_BUILD_COL;
      ST_BUILD_COL: if (mul_done && k == TW'(GRID_SIZE)) state_next = ST_BUILD_ROW;
      ST_BUILD_ROW: if (mul_done && k == TW'(GRID_SIZE)) state_next = ST_DECODE;
      ST_DECODE: begin
        if (!kind) state_next = load_out ? ST_IDLE : ST_FETCH;
        else       state_next = query_bad ? ST_OUT : ST_FETCH;
      end
      ST_FETCH:     state_next = ST_MUL;
      ST_MUL: begin
        if (mul_done) begin
          if (step != LAST_STEP) state_next = ST_FETCH;
          else                   state_next = kind ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT:       if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = state == ST_IDLE;
    mul_start = 1'b0;
    mul_x     = '0;
    pref_we   = 1'b0;
    col_we    = 1'b0;
    row_we    = 1'b0;
    tab_wa    = k;
    tab_wd    = mul_res;
    case (state)
      ST_BUILD_B: begin
        mul_start = !mul_busy && !mul_done;
        mul_x     = base_value;
        col_we    = mul_done;
        row_we    = mul_done;
        tab_wa    = '0;
        tab_wd    = one;
      end
      ST_BUILD_COL: begin
        mul_start = !mul_busy && !mul_done;
        mul_x     = pw;
        col_we    = mul_done;
      end
      ST_BUILD_ROW: begin
        mul_start = !mul_busy && !mul_done;
        mul_x     = pw;
        row_we    = mul_done;
      end
      ST_MUL: begin
        mul_start = !mul_busy && !mul_done;
        if (step == LAST_STEP)            mul_x = tmp;
        else if (!kind && step == 3'd0)   mul_x = word_t'(diff_abs);
        else                              mul_x = rd_ok ? pref_rd : '0;
        pref_we   = mul_done && !kind && step == LAST_STEP;
      end
      default: ;
    endcase
  end

  assign mul_phase = (state == ST_MUL) || (state == ST_BUILD_B) ||
                     (state == ST_BUILD_COL) || (state == ST_BUILD_ROW);

  rph2d_mulmod u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .m     (m_eff),
    .busy  (mul_busy),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_ff @(posedge clk) begin
    if (pref_we) prefix_store[wr_addr] <= acc_next;
    pref_rd <= prefix_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (col_we) col_pow[tab_wa] <= tab_wd;
    col_rd <= col_pow[w_idx];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_pow[tab_wa] <= tab_wd;
    row_rd <= row_pow[h_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      modulus      <= word_t'(1000000007);
      base_value   <= word_t'(131);
      min_char     <= 8'd48;
      powers_ready <= 1'b0;
      m_tvalid     <= 1'b0;
      step         <= '0;
      k            <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MODULUS: begin
            modulus      <= pwdata[WORD_W-1:0];
            powers_ready <= 1'b0;
          end
          REG_BASE: begin
            base_value   <= pwdata[WORD_W-1:0];
            powers_ready <= 1'b0;
          end
          REG_MINCHAR: min_char <= pwdata[7:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      if (in_acc) begin
        kind  <= s_tuser;
        ch    <= s_tdata[7:0];
        row_a <= s_tdata[17:8];
        col_a <= s_tdata[27:18];
        row_b <= s_tdata[37:28];
        col_b <= s_tdata[47:38];
      end
      case (state)
        ST_BUILD_B: if (mul_done) begin
          b_reg <= mul_res;
          pw    <= one;
          k     <= TW'(1);
        end
        ST_BUILD_COL: if (mul_done) begin
          if (k == TW'(GRID_SIZE)) begin
            rr_reg <= mul_res;
            pw     <= one;
            k      <= TW'(1);
          end else begin
            pw <= mul_res;
            k  <= k + 1'b1;
          end
        end
        ST_BUILD_ROW: if (mul_done) begin
          pw <= mul_res;
          k  <= k + 1'b1;
          if (k == TW'(GRID_SIZE)) powers_ready <= 1'b1;
        end
        ST_DECODE: begin
          step     <= '0;
          acc      <= '0;
          bad_flag <= query_bad;
        end
        ST_MUL: if (mul_done) begin
          step <= step + 1'b1;
          if (op == OP_TMP) tmp <= mul_res;
          else              acc <= acc_next;
        end
        ST_OUT: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata  <= {1'b0, acc};
          m_tuser  <= bad_flag;
        end
        default: ;
      endcase
    end
  end

  `RPH_ASSERT(a_ready_idle, clk, rst, s_tready |-> !mul_busy && !mul_done)
  `RPH_ASSERT(a_bad_zero, clk, rst, (m_tvalid && m_tuser) |-> m_tdata == 32'd0)
  `RPH_ASSERT(a_done_state, clk, rst, mul_done |-> mul_phase)
endmodule
`default_nettype wire

FILE: rtl/rph2d_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none
module rph2d_mulmod (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire rph2d_pkg::word_t x,
  input  wire rph2d_pkg::word_t y,
  input  wire rph2d_pkg::word_t m,
  output logic                busy,
  output logic                done,
  output rph2d_pkg::word_t    res
);
  import rph2d_pkg::*;

  word_t            acc;
  word_t            xs;
  word_t            ys;
  word_t            ms;
  logic [CNT_W-1:0] cnt;
  logic [WORD_W:0]  dbl;
  logic [WORD_W:0]  dbl_r;
  logic [WORD_W:0]  sum;
  logic [WORD_W:0]  sum_r;

  // The multiplicand y must be below m; x may be any value, so the
  // product is reduced along the way and x itself needs no reduction.
  always_comb begin
    dbl   = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, ms}) ? dbl - {1'b0, ms} : dbl;
    sum   = dbl_r + (xs[WORD_W-1] ? {1'b0, ys} : '0);
    sum_r = (sum >= {1'b0, ms}) ? sum - {1'b0, ms} : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WORD_W);
        acc  <= '0;
        xs   <= x;
        ys   <= y;
        ms   <= m;
      end else if (busy) begin
        acc <= sum_r[WORD_W-1:0];
        xs  <= {xs[WORD_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = acc;
endmodule
`default_nettype wire
